// ----- design/mud_pkg.sv -----
// Shared types and constants for the Manchester UART deframer.
`timescale 1ns / 1ps
`default_nettype none

package mud_pkg;

    localparam logic [1:0] PAIR_ZERO = 2'b10;
    localparam logic [1:0] PAIR_ONE  = 2'b01;

    localparam int FRAME_PAIRS = 10;
    localparam int BYTE_PAIRS  = 4;

    localparam logic [3:0] PHASE_START = 4'd0;
    localparam logic [3:0] PHASE_STOP  = 4'(FRAME_PAIRS - 1);

    typedef struct packed {
        logic [3:0] phase;
        logic [7:0] shift;
        logic       start_err;
        logic       code_err;
        logic       stop_err;
    } frame_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       start_error;
        logic       stop_error;
        logic       code_error;
    } frame_result_t;

endpackage

`default_nettype wire

// ----- design/mud_frame_step.sv -----
// Decodes the four Manchester pairs of one raw byte against the frame state.
`timescale 1ns / 1ps
`default_nettype none

module mud_frame_step
    import mud_pkg::*;
(
    input  wire logic [7:0]    raw_byte,
    input  wire logic          packet_start,
    input  wire frame_state_t  state_cur,
    output frame_state_t       state_next,
    output frame_result_t      result
);

    always_comb begin
        frame_state_t st;
        frame_result_t res;
        logic [1:0] pair;

        st  = state_cur;
        res = '0;
        if (packet_start || (st.phase > PHASE_STOP)) begin
            st.phase = PHASE_START;
        end
        for (int k = 0; k < BYTE_PAIRS; k++) begin
            pair = raw_byte[(BYTE_PAIRS - 1 - k) * 2 +: 2];
            if (st.phase == PHASE_START) begin
                st.shift     = '0;
                st.start_err = (pair != PAIR_ZERO);
                st.code_err  = 1'b0;
                st.stop_err  = 1'b0;
            end else if (st.phase == PHASE_STOP) begin
                if (pair != PAIR_ONE) begin
                    st.stop_err = 1'b1;
                end
                res.valid       = 1'b1;
                res.data_byte   = st.shift;
                res.start_error = st.start_err;
                res.stop_error  = st.stop_err;
                res.code_error  = st.code_err;
            end else begin
                st.shift = {(pair == PAIR_ONE), st.shift[7:1]};
                if ((pair != PAIR_ONE) && (pair != PAIR_ZERO)) begin
                    st.code_err = 1'b1;
                end
            end
            if (st.phase == PHASE_STOP) begin
                st.phase = PHASE_START;
            end else begin
                st.phase = st.phase + 4'd1;
            end
        end
        state_next = st;
        result     = res;
    end

endmodule

`default_nettype wire

// ----- design/manchester_uart_deframer_unit.sv -----
// Top level of the Manchester UART deframer: input register, frame state and result register.
//
// The input channel takes one raw radio byte per word: four Manchester pairs,
// first pair in bits 7:6, with s_packet_start marking the first byte of a packet.
// The result channel gives one decoded UART 8N1 data byte per completed frame,
// with flags for a bad start pair, a bad stop pair and an invalid data pair.
// A raw byte completes at most one frame, so most input words give no result.
// An accepted word is held in the input register until the result side
// can take it and is then decoded in a single pass; any result goes into
// the result register. One word is accepted every cycle while the result side keeps up.
// When the receiver stalls, the result register holds its word, the input
// register holds the next one, and s_ready drops only when both are full.
// Reset empties both registers and returns the frame phase to the start pair.
`timescale 1ns / 1ps
`default_nettype none

module manchester_uart_deframer_unit
    import mud_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_raw_byte,
    input  wire logic       s_packet_start,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic            m_start_error,
    output logic            m_stop_error,
    output logic            m_code_error
);

    logic          in_valid_reg;
    logic [7:0]    in_raw_reg;
    logic          in_pkt_reg;
    frame_state_t  state_reg;
    frame_state_t  state_next;
    frame_result_t step_result;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic          out_start_reg;
    logic          out_stop_reg;
    logic          out_code_reg;
    logic          advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mud_frame_step u_step (
        .raw_byte     (in_raw_reg),
        .packet_start (in_pkt_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_raw_reg <= s_raw_byte;
            in_pkt_reg <= s_packet_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_result.valid) begin
            out_data_reg  <= step_result.data_byte;
            out_start_reg <= step_result.start_error;
            out_stop_reg  <= step_result.stop_error;
            out_code_reg  <= step_result.code_error;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data_byte   = out_data_reg;
    assign m_start_error = out_start_reg;
    assign m_stop_error  = out_stop_reg;
    assign m_code_error  = out_code_reg;

endmodule

`default_nettype wire

// ----- design/mud_checker.sv -----
// Port-level assertions for the Manchester UART deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mud_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_data_byte,
    input wire logic       m_start_error,
    input wire logic       m_stop_error,
    input wire logic       m_code_error
);

    // Reset leaves no result word pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new result word rises only after the input word that causes it has been accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without a preceding input word");

    // The input side only blocks when both registers are full and the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the result side is free");

    // A stalled result word holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data_byte)
            && $stable(m_start_error) && $stable(m_stop_error) && $stable(m_code_error)))
        else $error("stalled result word changed");

endmodule

bind manchester_uart_deframer_unit mud_checker u_mud_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_byte   (m_data_byte),
    .m_start_error (m_start_error),
    .m_stop_error  (m_stop_error),
    .m_code_error  (m_code_error)
);

`default_nettype wire

// ----- verif/manchester_uart_deframer_unit_tb.sv -----
// Self-checking testbench for the Manchester UART deframer top level.
`timescale 1ns / 1ps

module manchester_uart_deframer_unit_tb;
    import mud_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 215;

    typedef struct packed {
        logic [7:0] raw;
        logic       pkt;
    } raw_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start_err;
        logic       stop_err;
        logic       code_err;
    } uart_frame_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_raw_byte = 8'h00;
    logic       s_packet_start = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data_byte;
    logic       m_start_error;
    logic       m_stop_error;
    logic       m_code_error;

    raw_word_t   pending_raw[$];
    uart_frame_t decoded_frames[$];
    logic [1:0]  pair_buf[$];

    logic [3:0]  rx_phase = PHASE_START;
    logic [7:0]  rx_shift = 8'h00;
    logic        rx_start_err = 1'b0;
    logic        rx_code_err = 1'b0;
    logic        rx_stop_err = 1'b0;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          errors = 0;
    int          cycles = 0;
    int          queued = 0;
    raw_word_t   tx_next;
    uart_frame_t got_frame;
    uart_frame_t want_frame;

    manchester_uart_deframer_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_byte     (s_raw_byte),
        .s_packet_start (s_packet_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_start_error  (m_start_error),
        .m_stop_error   (m_stop_error),
        .m_code_error   (m_code_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic deframe_raw_byte(input logic [7:0] raw, input logic pkt);
        logic [1:0] pair;
        if (pkt || rx_phase >= FRAME_PAIRS) begin
            rx_phase = PHASE_START;
        end
        for (int k = 0; k < BYTE_PAIRS; k++) begin
            pair = raw[7 - 2 * k -: 2];
            if (rx_phase == PHASE_START) begin
                rx_shift     = 8'h00;
                rx_start_err = (pair != PAIR_ZERO);
                rx_code_err  = 1'b0;
                rx_stop_err  = 1'b0;
            end else if (rx_phase == PHASE_STOP) begin
                if (pair != PAIR_ONE) begin
                    rx_stop_err = 1'b1;
                end
                decoded_frames.push_back('{rx_shift, rx_start_err, rx_stop_err, rx_code_err});
            end else begin
                rx_shift = {pair == PAIR_ONE, rx_shift[7:1]};
                if (pair != PAIR_ONE && pair != PAIR_ZERO) begin
                    rx_code_err = 1'b1;
                end
            end
            rx_phase = (rx_phase == PHASE_STOP) ? PHASE_START : rx_phase + 4'd1;
        end
    endtask

    task automatic push_raw(input logic [7:0] raw, input logic pkt);
        pending_raw.push_back('{raw, pkt});
        queued++;
    endtask

    task automatic push_frame(input logic [7:0] data, input logic [1:0] start_pair,
                              input logic [1:0] stop_pair, input logic [7:0] bad_bits,
                              input logic [1:0] bad_pair);
        pair_buf.push_back(start_pair);
        for (int i = 0; i < 8; i++) begin
            if (bad_bits[i]) begin
                pair_buf.push_back(bad_pair);
            end else begin
                pair_buf.push_back(data[i] ? PAIR_ONE : PAIR_ZERO);
            end
        end
        pair_buf.push_back(stop_pair);
    endtask

    // Pads the pending pairs with random ones to whole bytes and sends them as one packet.
    task automatic flush_packet();
        logic [7:0] raw;
        logic       first;
        first = 1'b1;
        while (pair_buf.size() % BYTE_PAIRS != 0) begin
            pair_buf.push_back(2'($urandom_range(3)));
        end
        while (pair_buf.size() > 0) begin
            for (int k = 0; k < BYTE_PAIRS; k++) begin
                raw[7 - 2 * k -: 2] = pair_buf.pop_front();
            end
            push_raw(raw, first);
            first = 1'b0;
        end
    endtask

    task automatic fill_random(input int target);
        int err_pct;
        int n;
        while (queued < target) begin
            if ($urandom_range(99) < 80) begin
                err_pct = ($urandom_range(2) == 0) ? 15 : 0;
                n = $urandom_range(1, 6);
                for (int f = 0; f < n; f++) begin
                    push_frame(8'($urandom_range(255)),
                               ($urandom_range(99) < err_pct) ? 2'($urandom_range(3)) : PAIR_ZERO,
                               ($urandom_range(99) < err_pct) ? 2'($urandom_range(3)) : PAIR_ONE,
                               ($urandom_range(99) < err_pct) ? 8'(1 << $urandom_range(7)) : 8'h00,
                               $urandom_range(1) ? 2'b00 : 2'b11);
                end
                if ($urandom_range(3) == 0) begin
                    pair_buf.push_back(2'($urandom_range(3)));
                end
                flush_packet();
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    push_raw(8'($urandom_range(255)), $urandom_range(99) < 30);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                deframe_raw_byte(s_raw_byte, s_packet_start);
            end
            if (!s_valid || s_ready) begin
                if (pending_raw.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_next = pending_raw.pop_front();
                    s_valid        <= 1'b1;
                    s_raw_byte     <= tx_next.raw;
                    s_packet_start <= tx_next.pkt;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_frame = '{m_data_byte, m_start_error, m_stop_error, m_code_error};
                if (decoded_frames.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %0h", $time, got_frame);
                    errors++;
                end else begin
                    want_frame = decoded_frames.pop_front();
                    check_field("data_byte", want_frame.data, got_frame.data);
                    check_field("start_error", 8'(want_frame.start_err),
                                8'(got_frame.start_err));
                    check_field("stop_error", 8'(want_frame.stop_err),
                                8'(got_frame.stop_err));
                    check_field("code_error", 8'(want_frame.code_err),
                                8'(got_frame.code_err));
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("manchester_uart_deframer_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 66 : 0;
            rx_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 22 : 0;
            if (ph == 0) begin
                push_frame(8'h00, PAIR_ZERO, PAIR_ONE, 8'h00, 2'b00);
                push_frame(8'hFF, PAIR_ZERO, PAIR_ONE, 8'h00, 2'b00);
                push_frame(8'hA5, PAIR_ZERO, PAIR_ONE, 8'h00, 2'b00);
                flush_packet();
                push_frame(8'h3C, 2'b01, PAIR_ONE, 8'h00, 2'b00);
                push_frame(8'h81, PAIR_ZERO, 2'b10, 8'h00, 2'b00);
                push_frame(8'h5A, PAIR_ZERO, PAIR_ONE, 8'h01, 2'b00);
                push_frame(8'hC3, 2'b11, 2'b00, 8'h80, 2'b11);
                flush_packet();
                pair_buf.push_back(PAIR_ZERO);
                for (int i = 0; i < 5; i++) begin
                    pair_buf.push_back(PAIR_ONE);
                end
                flush_packet();
                push_raw(8'h00, 1'b0);
                push_raw(8'hFF, 1'b0);
                push_raw(8'h55, 1'b1);
                push_raw(8'hAA, 1'b1);
            end
            fill_random(queued + PHASE_ITEMS);
            while (pending_raw.size() != 0 || s_valid) begin
                @(posedge aclk);
            end
            while (decoded_frames.size() != 0) begin
                @(posedge aclk);
            end
            repeat (DRAIN_CYCLES) @(posedge aclk);
            @(negedge aclk);
        end
        if (errors == 0) begin
            $display("manchester_uart_deframer_unit: match");
        end else begin
            $display("manchester_uart_deframer_unit: mismatch");
        end
        $finish;
    end

endmodule
